>>> hdl/efbc_pkg.sv
`timescale 1ns / 1ps

package efbc_pkg;

   localparam int IFG_BYTES = 12;
   localparam int HDR_BYTES = 22;
   localparam int PRE_BYTES = 8;
   localparam int CRC_BYTES = 4;
   localparam int CNT_W     = 5;

   localparam logic [31:0] CRC_POLY   = 32'h814141AB;
   localparam logic [31:0] CRC_INIT   = 32'h00000000;
   localparam logic [7:0]  BYTE_START = 8'hFB;
   localparam logic [7:0]  BYTE_PRE   = 8'h55;
   localparam logic [7:0]  BYTE_SFD   = 8'hD5;
   localparam logic [7:0]  BYTE_IDLE  = 8'h07;

   localparam logic [47:0] DEST_MAC_RESET   = 48'h0;
   localparam logic [47:0] SRC_MAC_RESET    = 48'h0;
   localparam logic [15:0] ETHER_TYPE_RESET = 16'hDDDD;

   typedef enum logic [1:0] {
      REG_DEST_MAC   = 2'd0,
      REG_SRC_MAC    = 2'd1,
      REG_ETHER_TYPE = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      KIND_PRE  = 3'd0,
      KIND_HDR  = 3'd1,
      KIND_PAY  = 3'd2,
      KIND_CRC  = 3'd3,
      KIND_IDLE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_HDR,
      ST_PAY,
      ST_CRC,
      ST_IDLE
   } stage_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   byte_kind;
      logic       last_of_run;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[31] ^ data[i];
         c  = {c[30:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                           input logic [47:0] dest,
                                           input logic [47:0] src,
                                           input logic [15:0] etype);
      logic [HDR_BYTES*8-1:0] hdr;
      logic [7:0]             base;
      hdr  = {BYTE_START, {6{BYTE_PRE}}, BYTE_SFD, dest, src, etype};
      base = 8'((HDR_BYTES - 1) * 8) - 8'({idx, 3'b000});
      if (32'(idx) >= HDR_BYTES) begin
         return 8'h00;
      end
      return hdr[base +: 8];
   endfunction

endpackage

>>> hdl/ethernet_frame_builder_crc_unit.sv
`timescale 1ns / 1ps

// Ethernet framer: one payload byte per transfer in, one line byte per transfer out.
// A byte marked first is preceded by 0xFB, six 0x55, the SFD 0xD5, destination MAC,
// source MAC and ether type (22 bytes); a byte marked last is followed by the CRC
// (polynomial 0x814141AB, initial value zero, MSB first, payload only), 12 idle
// bytes 0x07 and 0x07 padding up to a frame length that is a multiple of four.
// An input byte is registered in the sequencer, then in the single output register;
// plain payload bytes flow at one per cycle while the output is not stalled, a first
// byte holds the input during the header, a last byte during the CRC and trailer.
// Registers (csr_index): 0 destination MAC, 1 source MAC, 2 ether type
// (reset 0xDDDD); other indexes are ignored. Write only while the block is idle.

module ethernet_frame_builder_crc_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_byte_kind,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0]          dest_mac_ff, dest_mac_in;
   logic [47:0]          src_mac_ff, src_mac_in;
   logic [15:0]          ether_type_ff, ether_type_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   efbc_pkg::result_type rsp_ff, rsp_in;

   logic                 slot_free;
   logic                 busy;
   logic                 advance;
   logic                 load;
   logic                 gen_done;
   efbc_pkg::result_type gen;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign advance   = busy && slot_free;
   assign req_stall = busy && !(slot_free && gen_done);
   assign load      = req_valid && !req_stall;

   always_comb begin
      dest_mac_in   = dest_mac_ff;
      src_mac_in    = src_mac_ff;
      ether_type_in = ether_type_ff;
      if (csr_valid && csr_ready) begin
         case (efbc_pkg::reg_index_type'(csr_index))
            efbc_pkg::REG_DEST_MAC:   dest_mac_in   = csr_data;
            efbc_pkg::REG_SRC_MAC:    src_mac_in    = csr_data;
            efbc_pkg::REG_ETHER_TYPE: ether_type_in = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_mac_ff   <= efbc_pkg::DEST_MAC_RESET;
         src_mac_ff    <= efbc_pkg::SRC_MAC_RESET;
         ether_type_ff <= efbc_pkg::ETHER_TYPE_RESET;
      end else begin
         dest_mac_ff   <= dest_mac_in;
         src_mac_ff    <= src_mac_in;
         ether_type_ff <= ether_type_in;
      end
   end

   efbc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_byte  (req_payload_byte),
      .load_first (req_first_byte),
      .load_last  (req_last_byte),
      .advance    (advance),
      .dest_mac   (dest_mac_ff),
      .src_mac    (src_mac_ff),
      .ether_type (ether_type_ff),
      .busy       (busy),
      .gen        (gen),
      .gen_done   (gen_done)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (slot_free) begin
         rsp_valid_in = advance;
         rsp_in       = gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_byte_kind   = rsp_ff.byte_kind;
   assign rsp_last_of_run = rsp_ff.last_of_run;

endmodule

>>> hdl/efbc_seq.sv
`timescale 1ns / 1ps

module efbc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [7:0]             load_byte,
   input  logic                   load_first,
   input  logic                   load_last,
   input  logic                   advance,
   input  logic [47:0]            dest_mac,
   input  logic [47:0]            src_mac,
   input  logic [15:0]            ether_type,
   output logic                   busy,
   output efbc_pkg::result_type   gen,
   output logic                   gen_done
);

   logic                         hold_ff, hold_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         last_ff, last_in;
   efbc_pkg::stage_type          stage_ff, stage_in;
   logic [efbc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]                  crc_ff, crc_in;
   logic [1:0]                   phase_ff, phase_in;

   logic [1:0]                   phase_next;
   logic [efbc_pkg::CNT_W:0]     cnt_plus;
   logic                         trail_end_crc;
   logic                         trail_end_idle;

   assign busy       = hold_ff;
   assign phase_next = ((stage_ff == efbc_pkg::ST_HDR) && (cnt_ff == '0))
                       ? 2'd1 : phase_ff + 2'd1;
   assign cnt_plus   = {1'b0, cnt_ff} + (efbc_pkg::CNT_W+1)'(1);

   // trailer ends once the idle run is long enough and the frame is word aligned
   assign trail_end_crc  = (efbc_pkg::IFG_BYTES == 0) && (phase_next == 2'd0);
   assign trail_end_idle = (cnt_plus >= (efbc_pkg::CNT_W+1)'(efbc_pkg::IFG_BYTES))
                           && (phase_next == 2'd0);

   // output decode
   always_comb begin
      gen      = '0;
      gen_done = 1'b0;
      case (stage_ff)
         efbc_pkg::ST_HDR: begin
            gen.out_byte  = efbc_pkg::hdr_byte(cnt_ff, dest_mac, src_mac, ether_type);
            gen.byte_kind = (32'(cnt_ff) < efbc_pkg::PRE_BYTES)
                            ? efbc_pkg::KIND_PRE : efbc_pkg::KIND_HDR;
         end
         efbc_pkg::ST_PAY: begin
            gen.out_byte  = byte_ff;
            gen.byte_kind = efbc_pkg::KIND_PAY;
            gen_done      = !last_ff;
         end
         efbc_pkg::ST_CRC: begin
            gen.out_byte  = crc_ff[8*(3 - cnt_ff[1:0]) +: 8];
            gen.byte_kind = efbc_pkg::KIND_CRC;
            gen_done      = (32'(cnt_ff) == efbc_pkg::CRC_BYTES - 1) && trail_end_crc;
         end
         efbc_pkg::ST_IDLE: begin
            gen.out_byte  = efbc_pkg::BYTE_IDLE;
            gen.byte_kind = efbc_pkg::KIND_IDLE;
            gen_done      = trail_end_idle;
         end
         default: begin
            gen.out_byte  = efbc_pkg::BYTE_IDLE;
            gen.byte_kind = efbc_pkg::KIND_IDLE;
         end
      endcase
      gen.last_of_run = gen_done;
   end

   // next state
   always_comb begin
      hold_in  = hold_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      stage_in = stage_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      phase_in = phase_ff;
      if (advance && hold_ff) begin
         phase_in = phase_next;
         case (stage_ff)
            efbc_pkg::ST_HDR: begin
               if (cnt_ff == '0) begin
                  crc_in = efbc_pkg::CRC_INIT;
               end
               if (32'(cnt_ff) == efbc_pkg::HDR_BYTES - 1) begin
                  stage_in = efbc_pkg::ST_PAY;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_plus[efbc_pkg::CNT_W-1:0];
               end
            end
            efbc_pkg::ST_PAY: begin
               crc_in = efbc_pkg::crc_byte(crc_ff, byte_ff);
               if (last_ff) begin
                  stage_in = efbc_pkg::ST_CRC;
                  cnt_in   = '0;
               end
            end
            efbc_pkg::ST_CRC: begin
               if (32'(cnt_ff) == efbc_pkg::CRC_BYTES - 1) begin
                  stage_in = efbc_pkg::ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_plus[efbc_pkg::CNT_W-1:0];
               end
            end
            efbc_pkg::ST_IDLE: begin
               cnt_in = cnt_plus[efbc_pkg::CNT_W-1:0];
            end
            default: begin
               stage_in = efbc_pkg::ST_PAY;
            end
         endcase
         if (gen_done) begin
            hold_in = 1'b0;
            if (stage_ff != efbc_pkg::ST_PAY) begin
               crc_in   = efbc_pkg::CRC_INIT;
               phase_in = 2'd0;
            end
         end
      end
      if (load) begin
         hold_in  = 1'b1;
         byte_in  = load_byte;
         last_in  = load_last;
         stage_in = load_first ? efbc_pkg::ST_HDR : efbc_pkg::ST_PAY;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         stage_ff <= efbc_pkg::ST_PAY;
         cnt_ff   <= '0;
         crc_ff   <= efbc_pkg::CRC_INIT;
         phase_ff <= 2'd0;
      end else begin
         hold_ff  <= hold_in;
         stage_ff <= stage_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

>>> dv/ethernet_frame_builder_crc_unit_tb.sv
`timescale 1ns / 1ps

module ethernet_frame_builder_crc_unit_tb;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
      int         gap;
   } tx_byte_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_payload_byte = 8'h00;
   logic                    req_first_byte = 1'b0;
   logic                    req_last_byte = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_out_byte;
   logic [2:0]              rsp_byte_kind;
   logic                    rsp_last_of_run;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   efbc_pkg::reg_index_type csr_index = efbc_pkg::REG_DEST_MAC;
   logic [47:0]             csr_data = 48'h0;

   // predictor copy of the registers and frame state
   logic [47:0]             mac_dest = efbc_pkg::DEST_MAC_RESET;
   logic [47:0]             mac_src = efbc_pkg::SRC_MAC_RESET;
   logic [15:0]             type_field = efbc_pkg::ETHER_TYPE_RESET;
   logic [31:0]             frame_crc = 32'h0;
   logic [1:0]              frame_phase = 2'd0;

   efbc_pkg::result_type    run_buf [0:47];
   int                      run_len;
   efbc_pkg::result_type    line_bytes_due[$];
   tx_byte_type             payload_to_send[$];

   int                      bytes_queued = 0;
   int                      bytes_taken = 0;
   int                      mismatches = 0;
   int                      idle_mode = 1;
   int                      tx_wait = 0;
   int                      rx_wait = 0;
   logic                    req_taken = 1'b0;
   logic                    rsp_taken = 1'b0;
   logic                    freeze_req = 1'b0;
   logic                    rx_freeze = 1'b0;

   ethernet_frame_builder_crc_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload_byte(req_payload_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_kind   (rsp_byte_kind),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_wait();
      case (idle_mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
         default: return $urandom_range(0, 13);
      endcase
   endfunction

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int k = 7; k >= 0; k--) begin
         r = {r[30:0], 1'b0} ^ ((r[31] ^ d[k]) ? efbc_pkg::CRC_POLY : 32'h0);
      end
      return r;
   endfunction

   task automatic put_line(input logic [7:0] b, input efbc_pkg::kind_type kind);
      run_buf[run_len] = '{out_byte: b, byte_kind: kind, last_of_run: 1'b0};
      run_len++;
      frame_phase = frame_phase + 2'd1;
   endtask

   task automatic frame_predict(input logic [7:0] data, input logic first, input logic last);
      logic [111:0] hdr;
      logic [1:0]   pad;
      run_len = 0;
      if (first) begin
         frame_crc = 32'h0;
         frame_phase = 2'd0;
         put_line(efbc_pkg::BYTE_START, efbc_pkg::KIND_PRE);
         for (int k = 0; k < 6; k++) put_line(efbc_pkg::BYTE_PRE, efbc_pkg::KIND_PRE);
         put_line(efbc_pkg::BYTE_SFD, efbc_pkg::KIND_PRE);
         hdr = {mac_dest, mac_src, type_field};
         for (int k = 13; k >= 0; k--) put_line(hdr[k*8 +: 8], efbc_pkg::KIND_HDR);
      end
      put_line(data, efbc_pkg::KIND_PAY);
      frame_crc = crc_step(frame_crc, data);
      if (last) begin
         for (int k = 3; k >= 0; k--) put_line(frame_crc[k*8 +: 8], efbc_pkg::KIND_CRC);
         for (int k = 0; k < efbc_pkg::IFG_BYTES; k++) begin
            put_line(efbc_pkg::BYTE_IDLE, efbc_pkg::KIND_IDLE);
         end
         pad = 2'd0 - frame_phase;
         for (int k = 0; k < pad; k++) put_line(efbc_pkg::BYTE_IDLE, efbc_pkg::KIND_IDLE);
         frame_crc = 32'h0;
         frame_phase = 2'd0;
      end
      run_buf[run_len-1].last_of_run = 1'b1;
      for (int k = 0; k < run_len; k++) begin
         line_bytes_due.insert(line_bytes_due.size(), run_buf[k]);
      end
   endtask

   // sender
   always @(negedge clock) begin
      tx_byte_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (tx_wait > 0) begin
            tx_wait = tx_wait - 1;
            req_valid <= 1'b0;
         end else if (payload_to_send.size() > 0) begin
            nxt = payload_to_send.pop_front();
            req_valid <= 1'b1;
            req_payload_byte <= nxt.data;
            req_first_byte <= nxt.first;
            req_last_byte <= nxt.last;
            tx_wait = nxt.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rx_wait = pick_wait();
         if (rx_freeze) begin
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (freeze_req) begin
            freeze_req = 1'b0;
            rx_freeze = 1'b1;
            repeat (300) @(posedge clock);
            rx_freeze = 1'b0;
         end
      end
   end

   // monitor: check each result transfer, then predict from each input transfer
   always @(posedge clock) begin
      efbc_pkg::result_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (line_bytes_due.size() == 0) begin
               $display("%0t: unexpected byte %h kind %0d last %b", $time,
                        rsp_out_byte, rsp_byte_kind, rsp_last_of_run);
               mismatches++;
            end else begin
               due = line_bytes_due.pop_front();
               if (rsp_out_byte !== due.out_byte) begin
                  $display("%0t: out_byte expected %h got %h", $time,
                           due.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_byte_kind !== 3'(due.byte_kind)) begin
                  $display("%0t: byte_kind expected %0d got %0d", $time,
                           due.byte_kind, rsp_byte_kind);
                  mismatches++;
               end
               if (rsp_last_of_run !== due.last_of_run) begin
                  $display("%0t: last_of_run expected %b got %b", $time,
                           due.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            frame_predict(req_payload_byte, req_first_byte, req_last_byte);
            bytes_taken++;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
   end

   task automatic queue_byte(input logic [7:0] data, input logic first, input logic last);
      tx_byte_type b;
      b.data = data;
      b.first = first;
      b.last = last;
      b.gap = pick_wait();
      payload_to_send.insert(payload_to_send.size(), b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input int len, input bit opens, input bit closes);
      for (int k = 0; k < len; k++) begin
         queue_byte(8'($urandom), opens && k == 0, closes && k == len - 1);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (bytes_taken != bytes_queued || line_bytes_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input efbc_pkg::reg_index_type idx, input logic [47:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         efbc_pkg::REG_DEST_MAC:   mac_dest = val;
         efbc_pkg::REG_SRC_MAC:    mac_src = val;
         efbc_pkg::REG_ETHER_TYPE: type_field = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [47:0] pick_value(input int ph);
      case (ph)
         1: return '1;
         3: return '0;
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   initial begin
      int target;
      int r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h5A, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h7E, 1'b0, 1'b1);
      queue_byte(8'hA5, 1'b1, 1'b0);
      queue_byte(8'h3C, 1'b0, 1'b0);
      queue_byte(8'hC3, 1'b0, 1'b0);
      queue_byte(8'h96, 1'b0, 1'b1);
      // bytes with no frame open, then a frame dropped by a new first
      queue_byte(8'h42, 1'b0, 1'b0);
      queue_byte(8'h24, 1'b0, 1'b1);
      queue_byte(8'h11, 1'b1, 1'b0);
      queue_byte(8'h22, 1'b0, 1'b0);
      queue_byte(8'h33, 1'b1, 1'b1);
      wait_drained();
      csr_write(efbc_pkg::REG_DEST_MAC, '1);
      csr_write(efbc_pkg::REG_SRC_MAC, '0);
      csr_write(efbc_pkg::REG_ETHER_TYPE, 48'hFFFF_FFFF_0000);
      csr_write(efbc_pkg::REG_NONE, 48'h1234_5678_9ABC);
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b1);
      wait_drained();
      csr_write(efbc_pkg::REG_DEST_MAC, '0);
      csr_write(efbc_pkg::REG_SRC_MAC, '1);
      csr_write(efbc_pkg::REG_ETHER_TYPE, 48'h0000_0000_FFFF);
      queue_byte(8'hFF, 1'b1, 1'b1);

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         csr_write(efbc_pkg::REG_DEST_MAC, pick_value(ph));
         csr_write(efbc_pkg::REG_SRC_MAC, pick_value(ph));
         csr_write(efbc_pkg::REG_ETHER_TYPE, pick_value(ph));
         if (ph == 0) csr_write(efbc_pkg::REG_NONE, 48'({$urandom, $urandom}));
         idle_mode = ph % 3;
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps offering transfers
            idle_mode = 0;
            freeze_req = 1'b1;
            queue_frame(40, 1'b1, 1'b1);
            idle_mode = 2;
         end
         target = bytes_queued + 78;
         while (bytes_queued < target) begin
            r = $urandom_range(0, 19);
            if (r == 0) queue_frame($urandom_range(1, 3), 1'b0, 1'($urandom_range(0, 1)));
            else if (r == 1) queue_frame($urandom_range(1, 4), 1'b1, 1'b0);
            else if (r < 17) queue_frame($urandom_range(1, 8), 1'b1, 1'b1);
            else queue_frame($urandom_range(9, 40), 1'b1, 1'b1);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
